[hw/rtl/websocket_client_frame_deframer_core_assert.svh]
// Assertion macros used by the deframer core RTL.
`ifndef WEBSOCKET_CLIENT_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_CLIENT_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Clocked check, quiet while reset is held.
`define WSCFD_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WSCFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/wscfd_pkg.sv]
// Types and constants for the WebSocket client frame deframer.
package wscfd_pkg;

    // Result status codes
    localparam logic [2:0] ST_DATA  = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_PONG  = 3'd2;
    localparam logic [2:0] ST_CLOSE = 3'd3;
    localparam logic [2:0] ST_ERROR = 3'd4;

    // Frame opcodes
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Short length codes in the second header byte
    localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [3:0] EXT_BYTES_16  = 4'd2;
    localparam logic [3:0] EXT_BYTES_64  = 4'd8;

    localparam logic [23:0] MAX_PAYLOAD_RESET = 24'h080000;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic       frame_kind;
        logic       last;
    } t_result;

endpackage

[hw/rtl/websocket_client_frame_deframer_core.sv]
// WebSocket client-to-server frame deframer and payload unmasker.
//
// Takes one raw frame byte per cycle on s_axis while s_axis_tready is high
// and parses the header, the 16- or 64-bit extended length and the 4-byte
// mask key, then emits each text or ping payload byte unmasked on m_axis
// with tlast on the last one. The only per-byte work is the phase update,
// a 24-bit length decrement/compare and one XOR, all between the phase
// registers and the output register; a result that meets a full, stalled
// output register goes to the skid entry. A two-entry output stage (output
// register plus skid) keeps s_axis_tready high while one result waits on a stalled sink.
// Empty text/ping frames give one end marker, pong frames give one result
// at frame end, and an unmasked frame, a bad opcode or an oversized length
// gives an error result. After error or close the block swallows all input
// until reset. max_payload may only be written while the block is idle.
`include "websocket_client_frame_deframer_core_assert.svh"

module websocket_client_frame_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: max_payload
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    // request in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    // result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output logic        m_axis_tlast,   // last
    output logic [7:0]  m_axis_tuser    // [2:0] status, [3] frame_kind, [7:4] zero
);

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_HALTED
    } t_phase;

    t_phase               r_phase,     n_phase;
    logic [3:0]           r_opcode,    n_opcode;
    logic [3:0]           r_ext_left,  n_ext_left;
    logic [23:0]          r_len,       n_len;
    logic                 r_len_big,   n_len_big;
    logic [31:0]          r_key,       n_key;
    logic [1:0]           r_mask_pos,  n_mask_pos;
    logic [23:0]          r_max_payload;

    wscfd_pkg::t_result   r_out, r_skid, res;
    logic                 r_out_valid, r_skid_valid;
    logic                 res_valid;

    logic                 in_accept, out_pop, push;
    logic [7:0]           b;
    logic [7:0]           key_byte;
    logic [23:0]          len_shift, len_dec;
    logic                 len_big_shift;
    logic [23:0]          short_len;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = r_out_valid && m_axis_tready;
    assign push          = in_accept && res_valid;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.payload_byte;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = {4'b0000, r_out.frame_kind, r_out.status};

    // bits shifted out of the low 24 only matter as "too long"
    assign len_shift     = {r_len[15:0], b};
    assign len_big_shift = r_len_big || (r_len[23:16] != 8'd0);
    assign len_dec       = r_len - 24'd1;
    assign short_len     = {17'd0, b[6:0]};

    always_comb begin
        case (r_mask_pos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_opcode     = r_opcode;
        n_ext_left   = r_ext_left;
        n_len        = r_len;
        n_len_big    = r_len_big;
        n_key        = r_key;
        n_mask_pos   = r_mask_pos;
        res_valid    = 1'b0;
        res.status       = wscfd_pkg::ST_ERROR;
        res.payload_byte = 8'd0;
        res.frame_kind   = 1'b0;
        res.last         = 1'b1;

        unique case (r_phase)
            PH_HDR1: begin
                n_opcode = b[3:0];
                n_phase  = PH_HDR2;
            end
            PH_HDR2: begin
                if (!b[7]) begin
                    n_phase   = PH_HALTED;
                    res_valid = 1'b1;
                end else begin
                    unique case (r_opcode) inside
                        wscfd_pkg::OP_CLOSE: begin
                            n_phase    = PH_HALTED;
                            res_valid  = 1'b1;
                            res.status = wscfd_pkg::ST_CLOSE;
                        end
                        wscfd_pkg::OP_TEXT, wscfd_pkg::OP_PING, wscfd_pkg::OP_PONG: begin
                            n_len_big = 1'b0;
                            if (b[6:0] > wscfd_pkg::LEN_MAX_SHORT) begin
                                n_ext_left = (b[6:0] == wscfd_pkg::LEN_EXT64) ?
                                             wscfd_pkg::EXT_BYTES_64 :
                                             wscfd_pkg::EXT_BYTES_16;
                                n_len      = 24'd0;
                                n_phase    = PH_EXTLEN;
                            end else begin
                                n_len = short_len;
                                if (short_len > r_max_payload) begin
                                    n_phase   = PH_HALTED;
                                    res_valid = 1'b1;
                                end else begin
                                    n_key      = 32'd0;
                                    n_mask_pos = 2'd0;
                                    n_phase    = PH_MASK;
                                end
                            end
                        end
                        default: begin
                            n_phase   = PH_HALTED;
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            PH_EXTLEN: begin
                n_len      = len_shift;
                n_len_big  = len_big_shift;
                n_ext_left = r_ext_left - 4'd1;
                if (n_ext_left == 4'd0) begin
                    if (len_big_shift || (len_shift > r_max_payload)) begin
                        n_phase   = PH_HALTED;
                        res_valid = 1'b1;
                    end else begin
                        n_key      = 32'd0;
                        n_mask_pos = 2'd0;
                        n_phase    = PH_MASK;
                    end
                end
            end
            PH_MASK: begin
                n_key      = {r_key[23:0], b};
                n_mask_pos = r_mask_pos + 2'd1;
                if (n_mask_pos == 2'd0) begin
                    if (r_len == 24'd0) begin
                        n_phase   = PH_HDR1;
                        res_valid = 1'b1;
                        if (r_opcode == wscfd_pkg::OP_PONG) begin
                            res.status = wscfd_pkg::ST_PONG;
                        end else begin
                            res.status     = wscfd_pkg::ST_EMPTY;
                            res.frame_kind = (r_opcode == wscfd_pkg::OP_PING);
                        end
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_mask_pos = r_mask_pos + 2'd1;
                n_len      = len_dec;
                if (len_dec == 24'd0) begin
                    n_phase = PH_HDR1;
                end
                if (r_opcode == wscfd_pkg::OP_PONG) begin
                    // drop pong payload, report only its end
                    res_valid  = (len_dec == 24'd0);
                    res.status = wscfd_pkg::ST_PONG;
                end else begin
                    res_valid        = 1'b1;
                    res.status       = wscfd_pkg::ST_DATA;
                    res.payload_byte = b ^ key_byte;
                    res.frame_kind   = (r_opcode == wscfd_pkg::OP_PING);
                    res.last         = (len_dec == 24'd0);
                end
            end
            PH_HALTED: begin
                n_phase = PH_HALTED;
            end
            default: begin
                n_phase = PH_HALTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR1;
            r_opcode      <= 4'd0;
            r_ext_left    <= 4'd0;
            r_len         <= 24'd0;
            r_len_big     <= 1'b0;
            r_key         <= 32'd0;
            r_mask_pos    <= 2'd0;
            r_max_payload <= wscfd_pkg::MAX_PAYLOAD_RESET;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_payload <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_phase    <= n_phase;
                r_opcode   <= n_opcode;
                r_ext_left <= n_ext_left;
                r_len      <= n_len;
                r_len_big  <= n_len_big;
                r_key      <= n_key;
                r_mask_pos <= n_mask_pos;
            end
            // output register backed by one skid entry
            if (!r_out_valid || out_pop) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out        <= res;
                    r_out_valid  <= push;
                end
            end else if (push) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    `WSCFD_ASSERT_ALWAYS(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid holds data while output register is empty")
    `WSCFD_ASSERT_CLK(a_halt_after_stop, (push && (res.status == wscfd_pkg::ST_ERROR || res.status == wscfd_pkg::ST_CLOSE)) |=> (r_phase == PH_HALTED), "error or close did not halt the parser")
    `WSCFD_ASSERT_CLK(a_payload_len_live, (r_phase == PH_PAYLOAD) |-> (r_len != 24'd0 && !r_len_big), "payload phase with no bytes left or oversized length")
    `WSCFD_ASSERT_CLK(a_marker_shape, (m_axis_tvalid && m_axis_tuser[2:0] != wscfd_pkg::ST_DATA) |-> (m_axis_tlast && m_axis_tdata == 8'd0), "marker result without tlast or with payload")

endmodule
